@@ design/tgu_pkg.sv @@
// Shared types, register map and defaults for the gradient unfilter block.
// Holds the per-channel prediction function. Depends on nothing.
package tgu_pkg;

   localparam int MAX_ROW_PIXELS_DEFAULT = 2048;
   localparam int CHAN_W                 = 8;
   localparam int PACKED_W               = 3 * CHAN_W;
   localparam int WORD_W                 = 32;
   localparam int CSR_ADDR_W             = 5;
   localparam int CSR_DATA_W             = 32;

   typedef enum logic [2:0] {
      REG_ROW_WIDTH   = 3'd0,
      REG_RED_SHIFT   = 3'd1,
      REG_GREEN_SHIFT = 3'd2,
      REG_BLUE_SHIFT  = 3'd3,
      REG_RED_MAX     = 3'd4,
      REG_GREEN_MAX   = 3'd5,
      REG_BLUE_MAX    = 3'd6
   } csr_index_type;

   localparam logic [11:0] ROW_WIDTH_RESET   = 12'd2048;
   localparam logic [4:0]  RED_SHIFT_RESET   = 5'd16;
   localparam logic [4:0]  GREEN_SHIFT_RESET = 5'd8;
   localparam logic [4:0]  BLUE_SHIFT_RESET  = 5'd0;
   localparam logic [7:0]  MAX_RESET         = 8'd255;

   // above + left - upper_left, clamped to 0..max; first column takes above
   function automatic logic [CHAN_W-1:0] tgu_predict(
      input logic [CHAN_W-1:0] above,
      input logic [CHAN_W-1:0] left,
      input logic [CHAN_W-1:0] upper_left,
      input logic [CHAN_W-1:0] maxv,
      input logic              first_col
   );
      logic [CHAN_W+1:0] sum;
      logic [CHAN_W-1:0] pred;
      sum = {2'b00, above} + {2'b00, left} - {2'b00, upper_left};
      if (first_col) begin
         pred = above;
      end else if (sum[CHAN_W+1]) begin
         pred = '0;
      end else if (sum[CHAN_W:0] > {1'b0, maxv}) begin
         pred = maxv;
      end else begin
         pred = sum[CHAN_W-1:0];
      end
      return pred;
   endfunction

endpackage

@@ design/tgu_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module tgu_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/tight_gradient_unfilter.sv @@
// Top level of the gradient unfilter: register port, column tracking and the
// line-store read/modify/write loop. Depends on tgu_pkg and tgu_ram.
//
// Usage
//   Input channel (req_*): one filtered pixel word per beat, raster order,
//   req_rect_start high on the first pixel of each rectangle. A beat is
//   taken at a rising edge with req_valid high and req_stall low.
//   Result channel (rsp_*): one reconstructed colour word per input beat, in
//   order, with rsp_row_end marking the last pixel of each row.
//   Each result passes through the working stage and then the output register
//   before it shows on rsp_*.
//   Throughput: one pixel per cycle while rsp_stall is low, set by the
//   line-store loop: the entry above is read when the pixel is accepted and
//   written back as it leaves; a read of the column written then is forwarded.
//   Stall: while rsp_stall holds a waiting result, one more pixel is taken
//   into the working stage; after that req_stall rises until the output
//   register drains.
//   Reset: control state and registers return to their defaults. The line
//   store is not cleared and needs no pass; the first row of a rectangle
//   ignores what it reads from it.
//   Registers (psel/penable/pwrite APB-style, byte address 4*index) must be
//   written only while the block is idle; the block does not enforce this.
module tight_gradient_unfilter #(
   parameter int MAX_ROW_PIXELS = tgu_pkg::MAX_ROW_PIXELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tgu_pkg::WORD_W-1:0]       req_filtered_pixel,
   input  logic                             req_rect_start,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tgu_pkg::WORD_W-1:0]       rsp_color_word,
   output logic                             rsp_row_end,
   // register port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [tgu_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tgu_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tgu_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   import tgu_pkg::*;

   localparam int IDX_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_ROW_PIXELS + 1);
   localparam int CMP_W = (CNT_W > 12) ? CNT_W : 12;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [11:0]       row_width_ff;
   logic [4:0]        red_shift_ff, green_shift_ff, blue_shift_ff;
   logic [CHAN_W-1:0] red_max_ff, green_max_ff, blue_max_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= ROW_WIDTH_RESET;
         red_shift_ff   <= RED_SHIFT_RESET;
         green_shift_ff <= GREEN_SHIFT_RESET;
         blue_shift_ff  <= BLUE_SHIFT_RESET;
         red_max_ff     <= MAX_RESET;
         green_max_ff   <= MAX_RESET;
         blue_max_ff    <= MAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROW_WIDTH:   row_width_ff   <= pwdata[11:0];
            REG_RED_SHIFT:   red_shift_ff   <= pwdata[4:0];
            REG_GREEN_SHIFT: green_shift_ff <= pwdata[4:0];
            REG_BLUE_SHIFT:  blue_shift_ff  <= pwdata[4:0];
            REG_RED_MAX:     red_max_ff     <= pwdata[CHAN_W-1:0];
            REG_GREEN_MAX:   green_max_ff   <= pwdata[CHAN_W-1:0];
            REG_BLUE_MAX:    blue_max_ff    <= pwdata[CHAN_W-1:0];
            default: ;  // unmapped address: drop the write
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROW_WIDTH:   prdata = CSR_DATA_W'(row_width_ff);
         REG_RED_SHIFT:   prdata = CSR_DATA_W'(red_shift_ff);
         REG_GREEN_SHIFT: prdata = CSR_DATA_W'(green_shift_ff);
         REG_BLUE_SHIFT:  prdata = CSR_DATA_W'(blue_shift_ff);
         REG_RED_MAX:     prdata = CSR_DATA_W'(red_max_ff);
         REG_GREEN_MAX:   prdata = CSR_DATA_W'(green_max_ff);
         REG_BLUE_MAX:    prdata = CSR_DATA_W'(blue_max_ff);
         default:         prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake and stage occupancy
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_fire;
   logic accept;

   // The working stage moves on whenever the output register is free or
   // its beat is taken this cycle.
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Accept stage: column tracking and line-store read
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;
   logic [IDX_W-1:0] col_base, col0;
   logic             first_row_base, first_row0;
   logic [CMP_W-1:0] width_raw, width_cap, width_eff;
   logic             wrap, last0, first_col0;

   assign width_raw = CMP_W'(row_width_ff);
   assign width_cap = CMP_W'(MAX_ROW_PIXELS);

   always_comb begin
      // clamp the programmed width into 1..MAX_ROW_PIXELS
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > width_cap) begin
         width_eff = width_cap;
      end else begin
         width_eff = width_raw;
      end

      // a rectangle start restarts row tracking before the pixel is used
      col_base       = req_rect_start ? '0   : col_ff;
      first_row_base = req_rect_start ? 1'b1 : first_row_ff;

      // width shrunk under a running row: start a new row here
      wrap       = CMP_W'(col_base) >= width_eff;
      col0       = wrap ? '0 : col_base;
      first_row0 = wrap ? 1'b0 : first_row_base;
      first_col0 = (col0 == '0);
      last0      = CMP_W'(col0) == (width_eff - CMP_W'(1));

      col_in       = last0 ? '0 : (col0 + IDX_W'(1));
      first_row_in = last0 ? 1'b0 : first_row0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   // ------------------------------------------------------------------
   // Working stage: predict, reconstruct, write back
   // ------------------------------------------------------------------
   logic [WORD_W-1:0]   s1_pix_ff;
   logic [IDX_W-1:0]    s1_col_ff;
   logic                s1_first_col_ff, s1_first_row_ff, s1_last_ff;
   logic                fwd_ff;
   logic [PACKED_W-1:0] fwd_data_ff;
   logic [PACKED_W-1:0] left_ff, upper_left_ff;
   logic [PACKED_W-1:0] ram_rd_data, above_raw, above, packed_s1;
   logic [CHAN_W-1:0]   red_res, green_res, blue_res;
   logic [CHAN_W-1:0]   red_pred, green_pred, blue_pred;
   logic [WORD_W-1:0]   red_in, green_in, blue_in;
   logic [WORD_W-1:0]   color_word_s1;
   logic                fwd_in;

   // the pixel in the working stage writes the column this read wants
   assign fwd_in = s1_fire && (s1_col_ff == col0);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff       <= req_filtered_pixel;
         s1_col_ff       <= col0;
         s1_first_col_ff <= first_col0;
         s1_first_row_ff <= first_row0;
         s1_last_ff      <= last0;
         fwd_ff          <= fwd_in;
         fwd_data_ff     <= packed_s1;
      end
      if (s1_fire) begin
         left_ff       <= packed_s1;
         upper_left_ff <= above;
      end
   end

   tgu_ram #(
      .WIDTH  (PACKED_W),
      .DEPTH  (MAX_ROW_PIXELS),
      .ADDR_W (IDX_W)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (packed_s1),
      .rd_en   (accept),
      .rd_addr (col0),
      .rd_data (ram_rd_data)
   );

   assign above_raw = fwd_ff ? fwd_data_ff : ram_rd_data;
   // the first row sees a zero row above it
   assign above     = s1_first_row_ff ? '0 : above_raw;

   assign red_pred   = tgu_predict(above[23:16], left_ff[23:16], upper_left_ff[23:16],
                                   red_max_ff, s1_first_col_ff);
   assign green_pred = tgu_predict(above[15:8], left_ff[15:8], upper_left_ff[15:8],
                                   green_max_ff, s1_first_col_ff);
   assign blue_pred  = tgu_predict(above[7:0], left_ff[7:0], upper_left_ff[7:0],
                                   blue_max_ff, s1_first_col_ff);

   // only the low byte of each sum survives the mask, so add in 8 bits
   assign red_in   = s1_pix_ff >> red_shift_ff;
   assign green_in = s1_pix_ff >> green_shift_ff;
   assign blue_in  = s1_pix_ff >> blue_shift_ff;

   assign red_res   = (red_in[CHAN_W-1:0] + red_pred) & red_max_ff;
   assign green_res = (green_in[CHAN_W-1:0] + green_pred) & green_max_ff;
   assign blue_res  = (blue_in[CHAN_W-1:0] + blue_pred) & blue_max_ff;

   assign packed_s1 = {red_res, green_res, blue_res};

   // shifted channels add, so overlapping fields carry into each other
   assign color_word_s1 = (WORD_W'(red_res) << red_shift_ff)
                        + (WORD_W'(green_res) << green_shift_ff)
                        + (WORD_W'(blue_res) << blue_shift_ff);

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] rsp_color_word_ff;
   logic              rsp_row_end_ff;

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_color_word_ff <= color_word_s1;
         rsp_row_end_ff    <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_color_word = rsp_color_word_ff;
   assign rsp_row_end    = rsp_row_end_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("working stage advanced but output register is empty");

   a_stall_needs_busy_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty working stage");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while both stages are held");

   a_row_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && last0) |=> (col_ff == '0) && !first_row_ff)
      else $error("column tracking did not restart after a row end");

endmodule
